// File: sv/lru_page_replacement_core_assert.svh
// assertion macros for the lru page replacement core
// all three expect clk_i and rst_ni in the scope of the caller
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define LRUPR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LRUPR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

  // index and rank fields cover the largest frame count of 16
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned FRAME_W   = 2;
  localparam int unsigned FIU_W     = 3;
  localparam logic [FIU_W-1:0] FIU_RESET = 3'd3;
  localparam int unsigned CNT_W     = 32;

  // search record walking down the cell chain
  typedef struct packed {
    logic             go;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic             empty;
    logic [IDX_W-1:0] empty_idx;
    logic [IDX_W-1:0] best_rank;
    logic [IDX_W-1:0] best_idx;
  } scan_t;

  // update broadcast to all cells at commit
  typedef struct packed {
    logic             en;
    logic             fill;
    logic             age_all;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] limit;
  } upd_t;

endpackage

// File: sv/lrupr_cell.sv
`timescale 1ns / 1ps

module lrupr_cell #(
  parameter int unsigned FRAMES    = 4,
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 act_i,
  input  logic [PAGE_BITS-1:0] req_page_i,
  input  lrupr_pkg::scan_t     scan_i,
  output lrupr_pkg::scan_t     scan_o,
  input  lrupr_pkg::upd_t      upd_i,
  output logic [PAGE_BITS-1:0] page_o
);

  localparam int unsigned RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);
  localparam logic [lrupr_pkg::IDX_W-1:0] MY_IDX = lrupr_pkg::IDX_W'(IDX);

  logic [PAGE_BITS-1:0]          page_q;
  logic                          valid_q;
  logic [RW-1:0]                 rank_q;
  logic [lrupr_pkg::IDX_W-1:0]   rank_ext;
  lrupr_pkg::scan_t              scan_d, scan_q;

  assign rank_ext = lrupr_pkg::IDX_W'(rank_q);
  assign page_o   = page_q;
  assign scan_o   = scan_q;

  // local compare, first empty and oldest rank so far
  always_comb begin
    scan_d = scan_i;
    if (scan_i.go && act_i) begin
      if (!scan_i.hit && valid_q && (page_q == req_page_i)) begin
        scan_d.hit      = 1'b1;
        scan_d.hit_idx  = MY_IDX;
        scan_d.hit_rank = rank_ext;
      end
      if (!scan_i.empty && !valid_q) begin
        scan_d.empty     = 1'b1;
        scan_d.empty_idx = MY_IDX;
      end
      if (rank_ext > scan_i.best_rank) begin
        scan_d.best_rank = rank_ext;
        scan_d.best_idx  = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.en && act_i) begin
      if (upd_i.idx == MY_IDX) begin
        rank_q <= '0;
        if (upd_i.fill) begin
          page_q  <= req_page_i;
          valid_q <= 1'b1;
        end
      end else if (valid_q && (upd_i.age_all || (rank_ext < upd_i.limit))
                   && (rank_q != RANK_MAX)) begin
        rank_q <= rank_q + RW'(1);
      end
    end
  end

endmodule

// File: sv/lru_page_replacement_core.sv
`timescale 1ns / 1ps
// lru page replacement core
// input stream: one page reference per transaction, page number in s_axis_tdata
// output stream: one result per reference; tuser carries hit and evicted_valid,
//   tdata carries frame, evicted page and the saturating hit and fault totals
// config: cfg_we_i writes frames_in_use (0 acts as 1, above FRAMES acts as FRAMES);
//   write only while the core is idle
// path: a taken reference starts the token in go0_q, the token passes each cell
//   register, dec_q holds the decision and a commit loads the output register once free
// one reference at a time, taken only while idle; the search token walks the
//   chain of frame cells one cell per cycle and the decision then commits once
// the output register parts the two sides: a new reference is taken while the
//   previous result still waits; a stalled receiver holds the next commit
// reset: all frames empty, ranks and totals zero, frames_in_use back to 3
module lru_page_replacement_core #(
  parameter int unsigned FRAMES    = 4,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [lrupr_pkg::FIU_W-1:0] cfg_wdata_i,
  // reference stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0] s_axis_tdata,  // page
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // frame, evicted_page, hit_count, fault_count
  output logic [((lrupr_pkg::FRAME_W+PAGE_BITS+2*lrupr_pkg::CNT_W+7)/8)*8-1:0] m_axis_tdata,
  output logic [1:0]                  m_axis_tuser   // hit, evicted_valid
);

  localparam int unsigned IW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned OUT_W = ((lrupr_pkg::FRAME_W + PAGE_BITS
                                    + 2*lrupr_pkg::CNT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e                            state_q, state_d;
  logic [lrupr_pkg::FIU_W-1:0]       fiu_q;
  logic [lrupr_pkg::FIU_W-1:0]       n_act;
  logic [FRAMES-1:0]                 act;
  logic [PAGE_BITS-1:0]              req_q;
  logic                              go0_q;
  lrupr_pkg::scan_t                  rec_w [FRAMES+1];
  lrupr_pkg::scan_t                  dec_q;
  lrupr_pkg::upd_t                   upd;
  logic [PAGE_BITS-1:0]              page_w [FRAMES];
  logic [FRAMES:0]                   go_vec;

  logic                              s_acc, out_free, commit, c_evict;
  logic [lrupr_pkg::IDX_W-1:0]       c_idx;
  logic [PAGE_BITS-1:0]              c_ev_page;

  logic [lrupr_pkg::CNT_W-1:0]       hits_q, faults_q;
  logic                              m_valid_q;
  logic                              hit_q, ev_valid_q;
  logic [lrupr_pkg::FRAME_W-1:0]     frame_q;
  logic [PAGE_BITS-1:0]              ev_page_q;

  // handshakes
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign commit        = (state_q == S_COMMIT) && out_free;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= lrupr_pkg::FIU_RESET;
    end else if (cfg_we_i) begin
      fiu_q <= cfg_wdata_i;
    end
  end

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    n_act = fiu_q;
    if (fiu_q == '0) begin
      n_act = lrupr_pkg::FIU_W'(1);
    end else if (32'(fiu_q) > FRAMES) begin
      n_act = lrupr_pkg::FIU_W'(FRAMES);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_acc) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (rec_w[FRAMES].go) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go0_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      go0_q   <= s_acc;
    end
  end

  // request and decision hold registers
  always_ff @(posedge clk_i) begin
    if (s_acc) req_q <= s_axis_tdata[PAGE_BITS-1:0];
    if ((state_q == S_SCAN) && rec_w[FRAMES].go) dec_q <= rec_w[FRAMES];
  end

  // search token enters the head of the chain with nothing found yet
  always_comb begin
    rec_w[0]    = '0;
    rec_w[0].go = go0_q;
  end

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    assign act[k]    = (32'(n_act) > k);
    assign go_vec[k] = rec_w[k].go;

    lrupr_cell #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX       (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .act_i      (act[k]),
      .req_page_i (req_q),
      .scan_i     (rec_w[k]),
      .scan_o     (rec_w[k+1]),
      .upd_i      (upd),
      .page_o     (page_w[k])
    );
  end
  assign go_vec[FRAMES] = rec_w[FRAMES].go;

  // decision: hit frame, else first empty frame, else the oldest frame
  always_comb begin
    c_evict = !dec_q.hit && !dec_q.empty;
    if (dec_q.hit) begin
      c_idx = dec_q.hit_idx;
    end else if (dec_q.empty) begin
      c_idx = dec_q.empty_idx;
    end else begin
      c_idx = dec_q.best_idx;
    end
    c_ev_page = c_evict ? page_w[dec_q.best_idx[IW-1:0]] : '0;

    // a hit ages only the frames younger than it; a fill ages all of them
    upd.en      = commit;
    upd.fill    = !dec_q.hit;
    upd.age_all = !dec_q.hit;
    upd.idx     = c_idx;
    upd.limit   = dec_q.hit_rank;
  end

  // saturating totals, they also feed the result payload directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      faults_q <= '0;
    end else if (commit) begin
      if (dec_q.hit) begin
        if (hits_q != '1) hits_q <= hits_q + lrupr_pkg::CNT_W'(1);
      end else begin
        if (faults_q != '1) faults_q <= faults_q + lrupr_pkg::CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q      <= dec_q.hit;
      ev_valid_q <= c_evict;
      frame_q    <= c_idx[lrupr_pkg::FRAME_W-1:0];
      ev_page_q  <= c_ev_page;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = {ev_valid_q, hit_q};
  assign m_axis_tdata  = OUT_W'({faults_q, hits_q, ev_page_q, frame_q});

  // checks
`include "lru_page_replacement_core_assert.svh"

  `LRUPR_ASSERT_ALWAYS(a_one_token, $onehot0(go_vec), "more than one search token in the chain")
  `LRUPR_ASSERT_NEXT(a_accept_scan, s_acc, state_q == S_SCAN, "accepted reference did not start a search")
  `LRUPR_ASSERT_IMPLIES(a_result_from_commit, $rose(m_axis_tvalid), $past(state_q == S_COMMIT), "result appeared without a commit")
  `LRUPR_ASSERT_IMPLIES(a_evict_has_no_hit, m_axis_tvalid, !(hit_q && ev_valid_q), "hit reported together with an eviction")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_FRAMES = 4;
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned IDLE_LIMIT = 2000;   // cycles without any transaction
  localparam int unsigned TAIL_WAIT  = 20;     // wait after the drain before checking for missing results

  typedef struct packed {
    logic              hit;
    logic [1:0]        frame;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic [31:0]       hits;
    logic [31:0]       faults;
  } lru_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [PAGE_W-1:0] value;
    logic              has_exp;
    lru_result_t       exp;
  } stim_row_t;

  typedef struct packed {
    logic        has_exp;
    lru_result_t exp;
  } ref_note_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_TRICKLE} rx_mode_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [lrupr_pkg::FIU_W-1:0] cfg_wdata_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [15:0]                 s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [87:0]                 m_axis_tdata;
  logic [1:0]                  m_axis_tuser;

  // predictor state of the frame set
  logic [PAGE_W-1:0]           mdl_page [NUM_FRAMES];
  logic                        mdl_valid [NUM_FRAMES];
  int unsigned                 mdl_rank [NUM_FRAMES];
  logic [31:0]                 mdl_hits = '0;
  logic [31:0]                 mdl_faults = '0;
  logic [lrupr_pkg::FIU_W-1:0] mdl_fiu = lrupr_pkg::FIU_RESET;

  lru_result_t        pending_results [$];
  ref_note_t          ref_notes [$];
  stim_row_t          directed_rows [$];

  int unsigned        errors = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        refs_taken = 0;
  int unsigned        results_seen = 0;
  int unsigned        hits_seen = 0;
  int unsigned        evictions_seen = 0;
  int unsigned        cfg_writes = 0;
  int unsigned        burst_left = 0;
  rx_mode_e           rx_mode = RX_OPEN;
  int unsigned        rx_left = 0;

  lru_page_replacement_core #(
    .FRAMES    (NUM_FRAMES),
    .PAGE_BITS (PAGE_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    for (int k = 0; k < NUM_FRAMES; k++) begin
      mdl_page[k] = '0;
      mdl_valid[k] = 1'b0;
      mdl_rank[k] = 0;
    end
  end

  // ages valid active frames ranked below limit, then makes idx the newest
  function automatic void age_frames(int unsigned n, int unsigned idx, int unsigned limit);
    for (int k = 0; k < n; k++) begin
      if (k != idx && mdl_valid[k] && mdl_rank[k] < limit && mdl_rank[k] < NUM_FRAMES - 1)
        mdl_rank[k]++;
    end
    mdl_rank[idx] = 0;
  endfunction

  function automatic lru_result_t predict_reference(logic [PAGE_W-1:0] page);
    lru_result_t r;
    int unsigned n;
    int unsigned idx;
    int unsigned best;
    logic        found;
    r = '0;
    idx = 0;
    found = 1'b0;
    // zero acts as one frame, anything above the frame count saturates
    n = (mdl_fiu == 0) ? 1 : ((mdl_fiu > NUM_FRAMES) ? NUM_FRAMES : mdl_fiu);
    for (int k = 0; k < n; k++) begin
      if (!found && mdl_valid[k] && mdl_page[k] == page) begin
        found = 1'b1;
        idx = k;
      end
    end
    if (found) begin
      age_frames(n, idx, mdl_rank[idx]);
      if (mdl_hits != '1) mdl_hits++;
      r.hit = 1'b1;
    end else begin
      for (int k = 0; k < n; k++) begin
        if (!found && !mdl_valid[k]) begin
          found = 1'b1;
          idx = k;
        end
      end
      if (!found) begin
        // oldest rank loses, lowest index on a tie
        best = 0;
        idx = 0;
        for (int k = 0; k < n; k++) begin
          if (mdl_rank[k] > best) begin
            best = mdl_rank[k];
            idx = k;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page = mdl_page[idx];
      end
      mdl_page[idx] = page;
      mdl_valid[idx] = 1'b1;
      age_frames(n, idx, NUM_FRAMES);
      if (mdl_faults != '1) mdl_faults++;
    end
    r.frame = idx[1:0];
    r.hits = mdl_hits;
    r.faults = mdl_faults;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // monitor: predicts on every accepted reference, checks every accepted result
  always @(posedge clk_i) begin
    lru_result_t act;
    lru_result_t want;
    ref_note_t   note;
    logic        busy;
    busy = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        mdl_fiu = cfg_wdata_i;
        cfg_writes++;
        busy = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        note = ref_notes.pop_front();
        want = predict_reference(s_axis_tdata[PAGE_W-1:0]);
        pending_results.push_back(note.has_exp ? note.exp : want);
        refs_taken++;
        busy = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act.hit      = m_axis_tuser[0];
        act.ev_valid = m_axis_tuser[1];
        act.frame    = m_axis_tdata[1:0];
        act.ev_page  = m_axis_tdata[17:2];
        act.hits     = m_axis_tdata[49:18];
        act.faults   = m_axis_tdata[81:50];
        results_seen++;
        hits_seen += act.hit;
        evictions_seen += act.ev_valid;
        busy = 1'b1;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, act);
        end else begin
          want = pending_results.pop_front();
          check_field("hit", want.hit, act.hit);
          check_field("frame", want.frame, act.frame);
          check_field("evicted_valid", want.ev_valid, act.ev_valid);
          check_field("evicted_page", want.ev_page, act.ev_page);
          check_field("hit_count", want.hits, act.hits);
          check_field("fault_count", want.faults, act.faults);
        end
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
    end
  end

  // receiver backpressure, switching between patterns
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_EVERY4: m_axis_tready <= (rx_left[1:0] == 2'd0);
      default:   m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic lru_result_t mk_result(logic hit, logic [1:0] frame, logic evv,
                                            logic [PAGE_W-1:0] evp, logic [31:0] h,
                                            logic [31:0] f);
    return '{hit: hit, frame: frame, ev_valid: evv, ev_page: evp, hits: h, faults: f};
  endfunction

  function automatic void add_row(row_kind_e kind, logic [PAGE_W-1:0] value,
                                  logic has_exp = 1'b0, lru_result_t exp = '0);
    directed_rows.push_back('{kind: kind, value: value, has_exp: has_exp, exp: exp});
  endfunction

  // one reference per call; the sender runs in bursts with random gaps
  task automatic send_ref(logic [PAGE_W-1:0] page, logic has_exp = 1'b0,
                          lru_result_t exp = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    ref_notes.push_back('{has_exp: has_exp, exp: exp});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= page;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // frames_in_use is only written with the core empty
  task automatic write_frames(logic [lrupr_pkg::FIU_W-1:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [2:0]        settings [12];
    logic [PAGE_W-1:0] pool [8];
    logic [PAGE_W-1:0] page;
    int unsigned       pool_n;
    int unsigned       pick;

    // reset frame count of three: cold fills, a hit, then eviction of page zero
    add_row(ROW_REF, 16'h0000, 1'b1, mk_result(1'b0, 2'd0, 1'b0, 16'h0000, 0, 1));
    add_row(ROW_REF, 16'h0000, 1'b1, mk_result(1'b1, 2'd0, 1'b0, 16'h0000, 1, 1));
    add_row(ROW_REF, 16'hffff, 1'b1, mk_result(1'b0, 2'd1, 1'b0, 16'h0000, 1, 2));
    add_row(ROW_REF, 16'h5555, 1'b1, mk_result(1'b0, 2'd2, 1'b0, 16'h0000, 1, 3));
    add_row(ROW_REF, 16'haaaa, 1'b1, mk_result(1'b0, 2'd0, 1'b1, 16'h0000, 1, 4));
    add_row(ROW_REF, 16'hffff);
    add_row(ROW_REF, 16'h0001);
    // above the frame count saturates to four
    add_row(ROW_CFG, 16'd7);
    add_row(ROW_REF, 16'h1234);
    add_row(ROW_REF, 16'h8000);
    add_row(ROW_REF, 16'haaaa);
    // zero acts as a single frame
    add_row(ROW_CFG, 16'd0);
    add_row(ROW_REF, 16'h5555);
    add_row(ROW_REF, 16'h5555);
    add_row(ROW_REF, 16'h7fff);
    // shrunk set: upper frames keep pages but are not searched
    add_row(ROW_CFG, 16'd2);
    add_row(ROW_REF, 16'h1234);
    add_row(ROW_REF, 16'h00ff);
    add_row(ROW_REF, 16'hff00);
    // grow again: the kept frames come back with stale ranks
    add_row(ROW_CFG, 16'd4);
    add_row(ROW_REF, 16'h1234);
    add_row(ROW_REF, 16'h0f0f);
    add_row(ROW_REF, 16'hf0f0);
    add_row(ROW_REF, 16'h8000);
    add_row(ROW_CFG, 16'd1);
    add_row(ROW_REF, 16'h0000);
    add_row(ROW_REF, 16'hffff);

    settings = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd4, 3'd1, 3'd5, 3'd3, 3'd6, 3'd2};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_frames(directed_rows[i].value[lrupr_pkg::FIU_W-1:0]);
      else
        send_ref(directed_rows[i].value, directed_rows[i].has_exp, directed_rows[i].exp);
    end

    // random phases: a small working set per phase so hits, fills and
    // evictions all occur, with some fully random and one-bit-flipped pages mixed in
    foreach (settings[s]) begin
      write_frames(settings[s]);
      pool_n = $urandom_range(2, 8);
      for (int k = 0; k < 8; k++) pool[k] = PAGE_W'($urandom_range(0, 16'hffff));
      if ($urandom_range(0, 1)) pool[0] = 16'h0000;
      if ($urandom_range(0, 1)) pool[1] = 16'hffff;
      repeat (86) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)
          page = pool[$urandom_range(0, pool_n - 1)];
        else if (pick < 9)
          page = PAGE_W'($urandom_range(0, 16'hffff));
        else
          page = pool[$urandom_range(0, pool_n - 1)] ^ (16'h1 << $urandom_range(0, 15));
        send_ref(page);
      end
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

    $display("covered %0d references and %0d results over %0d frame count writes",
             refs_taken, results_seen, cfg_writes);
    $display("seen %0d hits, %0d faults, %0d evictions, %0d mismatches",
             hits_seen, results_seen - hits_seen, evictions_seen, errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
